// ===== src/tca_pkg.sv =====
// Shared types and constants of the two-color attribute encoder.
`default_nettype none

package tca_pkg;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIXUP_COLOR = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TO8_MODE    = 1'd1;

   localparam logic [4:0] FIXUP_COLOR_RESET = 5'h1F;
   localparam logic       TO8_MODE_RESET    = 1'b0;

   localparam logic [7:0] FORM_ALL_ONES = 8'hFF;
   localparam logic [3:0] GLITCH_LOW    = 4'h7;
   localparam logic [7:0] REMAP_INVERT  = 8'hC0;

   typedef struct packed {
      logic [3:0] pixel0;
      logic [3:0] pixel1;
      logic [3:0] pixel2;
      logic [3:0] pixel3;
      logic [3:0] pixel4;
      logic [3:0] pixel5;
      logic [3:0] pixel6;
      logic [3:0] pixel7;
      logic       end_of_image;
   } req_type;

   typedef struct packed {
      logic [7:0] form_byte;
      logic [7:0] color_byte;
      logic       color_clash;
   } rsp_type;

   // Result of sorting one group into background, foreground and clashes.
   typedef struct packed {
      logic [3:0] back;
      logic [3:0] fore;
      logic       have_fore;
      logic [7:0] form;
      logic       clash;
      logic       last_bit;
   } class_type;

endpackage

`default_nettype wire

// ===== src/two_color_attribute_encoder.sv =====
// Top level of the two-color attribute encoder: registers, flag and handshakes.
//
// Usage: each word on the req_ channel is a group of eight 4-bit color indices,
// pixel0 leftmost, plus an end_of_image bit on the last group of a picture.
// Each group gives exactly one word on the rsp_ channel: the form byte, the
// color byte and a clash bit. A word moves when its valid is high and its
// stall is low.
// A group is taken into an input register, encoded by a single pass of logic
// and stored in the output register when it advances; the result is offered
// from there. One group is accepted every cycle while rsp_stall is low.
// The last-form flag is updated as a group enters the output register, so the
// next group sees it at once. While the receiver stalls, the output register
// holds its word and the input register takes one more group; then req_stall
// rises until the output moves.
// The csr_ port writes fixup_color (index 0) and to8_mode (index 1) while the
// block is idle; the user must keep to this, the block does not enforce it.
// Synchronous reset: both registers empty, flag 0, fixup_color -1, to8_mode 0.
`default_nettype none

module two_color_attribute_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tca_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tca_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [tca_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tca_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   logic              in_valid_ff;
   tca_pkg::req_type  in_data_ff;
   logic              out_valid_ff;
   tca_pkg::rsp_type  out_data_ff;
   logic              flag_ff;
   logic              flag_in;
   logic [4:0]        fixup_ff;
   logic              to8_ff;
   logic              advance;
   logic              req_take;
   tca_pkg::class_type cls;
   tca_pkg::rsp_type  word;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   tca_classify u_classify (
      .group  (in_data_ff),
      .result (cls)
   );

   tca_adjust u_adjust (
      .cls          (cls),
      .fixup_color  (fixup_ff),
      .to8_mode     (to8_ff),
      .prev_flag    (flag_ff),
      .end_of_image (in_data_ff.end_of_image),
      .word         (word),
      .next_flag    (flag_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
         fixup_ff     <= tca_pkg::FIXUP_COLOR_RESET;
         to8_ff       <= tca_pkg::TO8_MODE_RESET;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            flag_ff      <= flag_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               tca_pkg::CSR_FIXUP_COLOR: fixup_ff <= csr_data[4:0];
               tca_pkg::CSR_TO8_MODE:    to8_ff   <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   // The flag moves only when a group passes into the output register.
   a_flag_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flag_ff))
      else $error("last-form flag changed without a group advancing");

   // The last group of a picture always leaves the flag cleared.
   a_eoi_clears_flag: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.end_of_image |=> !flag_ff)
      else $error("end of image did not clear the last-form flag");

   // A group that cannot advance stays in the input register.
   a_group_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("a stalled group was dropped from the input register");

   // An advancing group always produces an output word.
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("an advancing group left no output word");
`endif

endmodule

`default_nettype wire

// ===== src/tca_classify.sv =====
// Sorts the eight pixels of a group into background, foreground and clash pixels.
`default_nettype none

module tca_classify (
   input  tca_pkg::req_type   group,
   output tca_pkg::class_type result
);

   logic [3:0] pix [8];

   assign pix[0] = group.pixel0;
   assign pix[1] = group.pixel1;
   assign pix[2] = group.pixel2;
   assign pix[3] = group.pixel3;
   assign pix[4] = group.pixel4;
   assign pix[5] = group.pixel5;
   assign pix[6] = group.pixel6;
   assign pix[7] = group.pixel7;

   always_comb begin
      logic have_back;
      have_back = 1'b0;
      result    = '0;
      for (int i = 0; i < 8; i++) begin
         if (have_back && pix[i] == result.back) begin
            result.last_bit = 1'b0;
         end else if (result.have_fore && pix[i] == result.fore) begin
            result.form[3'(7 - i)] = 1'b1;
            result.last_bit        = 1'b1;
         end else if (!have_back) begin
            result.back     = pix[i];
            have_back       = 1'b1;
            result.last_bit = 1'b0;
         end else if (!result.have_fore) begin
            result.fore            = pix[i];
            result.have_fore       = 1'b1;
            result.form[3'(7 - i)] = 1'b1;
            result.last_bit        = 1'b1;
         end else begin
            // A third color leaves the form bit and the flag alone.
            result.clash = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/tca_adjust.sv =====
// Applies the swap, glitch fix and color remap to a classified group.
`default_nettype none

module tca_adjust (
   input  tca_pkg::class_type cls,
   input  logic [4:0]         fixup_color,
   input  logic               to8_mode,
   input  logic               prev_flag,
   input  logic               end_of_image,
   output tca_pkg::rsp_type   word,
   output logic               next_flag
);

   logic fix_neg;
   logic fix_pos;

   assign fix_neg = fixup_color[4];
   assign fix_pos = !fixup_color[4] && (fixup_color[3:0] != 4'd0);

   always_comb begin
      logic [3:0] back;
      logic [3:0] fore;
      logic [7:0] form;
      logic [7:0] color;
      logic       flag;
      back = cls.back;
      fore = cls.fore;
      form = cls.form;
      flag = cls.last_bit;

      if (!cls.have_fore) begin
         fore = fixup_color[3:0];
      end else if (fix_neg && (cls.back == 4'd1 || cls.fore == 4'd0)) begin
         back = cls.fore;
         fore = cls.back;
         form = ~cls.form;
      end

      color = {fore, back};

      // Keep the first form bit in line with the previous group's last one.
      if (fix_pos) begin
         if ((form != 8'd0 && prev_flag != form[7]) || form == tca_pkg::FORM_ALL_ONES) begin
            color = {back, tca_pkg::GLITCH_LOW};
            form  = form ^ tca_pkg::FORM_ALL_ONES;
            flag  = !flag;
         end
      end

      if (to8_mode) begin
         color = {color[3], color[7:4], color[2:0]} ^ tca_pkg::REMAP_INVERT;
      end

      word.form_byte   = form;
      word.color_byte  = color;
      word.color_clash = cls.clash;
      next_flag        = end_of_image ? 1'b0 : flag;
   end

endmodule

`default_nettype wire
